>>> rtl/core/model_primitive_packet_decoder_unit_macros.svh
// Assertion macros used by the decode module of the primitive packet decoder.
`ifndef MODEL_PRIMITIVE_PACKET_DECODER_UNIT_MACROS_SVH
`define MODEL_PRIMITIVE_PACKET_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmpd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmpd assertion failed");

`endif

>>> rtl/core/pmpd_pkg.sv
// Types, codes and mode tables for the primitive packet decoder.
`default_nettype none

package pmpd_pkg;

	localparam logic [7:0] MODE_FLAT_TRI    = 8'h20;
	localparam logic [7:0] MODE_GOURAUD_TRI = 8'h21;
	localparam logic [7:0] MODE_FLAT_QUAD   = 8'h28;
	localparam logic [7:0] MODE_GOURAUD_QUAD = 8'h29;

	localparam logic [3:0] MIN_FLAT_TRI     = 4'(16 / 4);
	localparam logic [3:0] MIN_GOURAUD_TRI  = 4'(24 / 4);
	localparam logic [3:0] MIN_FLAT_QUAD    = 4'(20 / 4);
	localparam logic [3:0] MIN_GOURAUD_QUAD = 4'(32 / 4);

	localparam logic [15:0] PRIM_COUNT_RESET = 16'd1;

	// Reciprocal of three in 11 fractional bits, exact for 10-bit sums.
	localparam logic [19:0] RECIP_THREE = 20'd683;

	typedef enum logic [2:0] {
		ST_PRIM      = 3'd0,
		ST_PRIM_DONE = 3'd1,
		ST_DONE      = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_TRUNC     = 3'd4
	} status_t;

	typedef struct packed {
		logic        block_start;
		logic [31:0] data_word;
		logic        data_end;
	} in_beat_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] vertex_a;
		logic [15:0] vertex_b;
		logic [15:0] vertex_c;
		logic [15:0] vertex_d;
		logic        quad_flag;
	} result_t;

	function automatic logic [2:0] colour_words(input logic [7:0] mode);
		case (mode)
			MODE_FLAT_TRI, MODE_FLAT_QUAD: colour_words = 3'd1;
			MODE_GOURAUD_TRI:              colour_words = 3'd3;
			MODE_GOURAUD_QUAD:             colour_words = 3'd4;
			default:                       colour_words = 3'd0;
		endcase
	endfunction

	function automatic logic [2:0] vertex_word(input logic [7:0] mode);
		case (mode)
			MODE_FLAT_TRI, MODE_FLAT_QUAD: vertex_word = 3'd2;
			MODE_GOURAUD_TRI:              vertex_word = 3'd3;
			MODE_GOURAUD_QUAD:             vertex_word = 3'd4;
			default:                       vertex_word = 3'd0;
		endcase
	endfunction

	function automatic logic [3:0] min_words(input logic [7:0] mode);
		case (mode)
			MODE_FLAT_TRI:     min_words = MIN_FLAT_TRI;
			MODE_GOURAUD_TRI:  min_words = MIN_GOURAUD_TRI;
			MODE_FLAT_QUAD:    min_words = MIN_FLAT_QUAD;
			MODE_GOURAUD_QUAD: min_words = MIN_GOURAUD_QUAD;
			default:           min_words = 4'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/pmpd_in_stage.sv
// Input register stage that captures one word beat and holds it for the decoder.
`default_nettype none

module pmpd_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pmpd_pkg::in_beat_t in_beat,
	input  wire logic              advance,
	output logic                   valid_s1,
	output pmpd_pkg::in_beat_t     beat_s1
);

	logic accept;

	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pmpd_decode.sv
// Packet parser state and per-word decode that forms at most one result per beat.
`default_nettype none

`include "model_primitive_packet_decoder_unit_macros.svh"

module pmpd_decode (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [15:0]        cfg_wr_data,
	input  wire logic               advance,
	input  wire pmpd_pkg::in_beat_t beat_s1,
	output logic                    res_valid,
	output pmpd_pkg::result_t       res
);

	logic [15:0] count_q;
	logic [7:0]  pos_q;
	logic [7:0]  pw_q;
	logic [7:0]  mode_q;
	logic [9:0]  sums_q [3];
	logic [15:0] verts_q [4];
	logic [15:0] pd_q;
	logic        active_q;

	logic [7:0]  pos_n;
	logic [7:0]  pw_n;
	logic [7:0]  mode_n;
	logic [9:0]  sums_n [3];
	logic [15:0] verts_n [4];
	logic [15:0] pd_n;
	logic        active_n;

	logic [31:0] w;
	logic [7:0]  pos;
	logic [15:0] pd_base;
	logic        act;
	logic [7:0]  vw;
	logic        last;
	logic        over;
	logic [3:0]  minw;
	logic        quad;
	logic [19:0] prod [3];
	logic [7:0]  col [3];

	always_comb begin
		w       = beat_s1.data_word;
		pos     = beat_s1.block_start ? 8'd0 : pos_q;
		pd_base = beat_s1.block_start ? 16'd0 : pd_q;
		act     = beat_s1.block_start ? 1'b1 : active_q;

		pos_n    = pos;
		pd_n     = pd_base;
		active_n = act;
		pw_n     = (pos == 8'd1) ? w[15:8] : pw_q;
		mode_n   = (pos == 8'd0) ? w[31:24] : mode_q;
		vw       = {5'd0, pmpd_pkg::vertex_word(mode_n)};

		for (int k = 0; k < 3; k++) begin
			sums_n[k] = (pos == 8'd0) ? 10'd0 : sums_q[k];
			if (pos < {5'd0, pmpd_pkg::colour_words(mode_n)}) begin
				sums_n[k] = sums_n[k] + {2'd0, w[8*k +: 8]};
			end
		end
		for (int k = 0; k < 4; k++) begin
			verts_n[k] = (pos == 8'd0) ? 16'd0 : verts_q[k];
		end
		if (vw != 8'd0 && pos == vw) begin
			verts_n[0] = w[15:0];
			verts_n[1] = w[31:16];
		end
		if (vw != 8'd0 && pos == vw + 8'd1) begin
			verts_n[2] = w[15:0];
			verts_n[3] = w[31:16];
		end

		last = (pos != 8'd0) && ({1'b0, pos} + 9'd1 == {1'b0, pw_n});
		minw = pmpd_pkg::min_words(mode_n);
		quad = (mode_n == pmpd_pkg::MODE_FLAT_QUAD) || (mode_n == pmpd_pkg::MODE_GOURAUD_QUAD);
		over = 1'b0;

		// Colour sums are complete before the last word of any valid packet.
		for (int k = 0; k < 3; k++) begin
			prod[k] = {10'd0, sums_q[k]} * pmpd_pkg::RECIP_THREE;
			if (mode_n == pmpd_pkg::MODE_GOURAUD_TRI) begin
				col[k] = prod[k][18:11];
			end else if (mode_n == pmpd_pkg::MODE_GOURAUD_QUAD) begin
				col[k] = sums_q[k][9:2];
			end else begin
				col[k] = sums_q[k][7:0];
			end
		end

		res_valid = 1'b0;
		res       = '0;
		res.status = pmpd_pkg::ST_PRIM;

		if (beat_s1.block_start && count_q == 16'd0) begin
			active_n   = 1'b0;
			res_valid  = 1'b1;
			res.status = pmpd_pkg::ST_DONE;
		end else if (act) begin
			if (pos == 8'd1 && pw_n < 8'd2) begin
				active_n   = 1'b0;
				res_valid  = 1'b1;
				res.status = pmpd_pkg::ST_BAD_LEN;
			end else if (!last) begin
				if (beat_s1.data_end) begin
					active_n   = 1'b0;
					res_valid  = 1'b1;
					res.status = pmpd_pkg::ST_TRUNC;
				end else begin
					pos_n = pos + 8'd1;
				end
			end else begin
				pos_n    = 8'd0;
				pd_n     = pd_base + 16'd1;
				over     = (pd_n >= count_q) || beat_s1.data_end;
				active_n = !over;
				if (minw == 4'd0 || pw_n < {4'd0, minw}) begin
					if (over) begin
						res_valid  = 1'b1;
						res.status = pmpd_pkg::ST_DONE;
					end
				end else begin
					res_valid     = 1'b1;
					res.status    = over ? pmpd_pkg::ST_PRIM_DONE : pmpd_pkg::ST_PRIM;
					res.red       = col[0];
					res.green     = col[1];
					res.blue      = col[2];
					res.vertex_a  = verts_n[0];
					res.vertex_b  = verts_n[1];
					res.vertex_c  = verts_n[2];
					res.vertex_d  = quad ? verts_n[3] : 16'd0;
					res.quad_flag = quad;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= pmpd_pkg::PRIM_COUNT_RESET;
			pos_q    <= 8'd0;
			pw_q     <= 8'd0;
			mode_q   <= 8'd0;
			pd_q     <= 16'd0;
			active_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				sums_q[k] <= 10'd0;
			end
			for (int k = 0; k < 4; k++) begin
				verts_q[k] <= 16'd0;
			end
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			if (advance) begin
				pd_q     <= pd_n;
				active_q <= active_n;
				if (act && !(beat_s1.block_start && count_q == 16'd0)) begin
					pos_q  <= pos_n;
					pw_q   <= pw_n;
					mode_q <= mode_n;
					for (int k = 0; k < 3; k++) begin
						sums_q[k] <= sums_n[k];
					end
					for (int k = 0; k < 4; k++) begin
						verts_q[k] <= verts_n[k];
					end
				end else begin
					pos_q <= pos;
				end
			end
		end
	end

	`PMPD_ASSERT_NOW(a_idle_silent, clk, arst_n, advance && !beat_s1.block_start && !active_q, !res_valid)
	`PMPD_ASSERT_NEXT(a_stop_idles, clk, arst_n, advance && res_valid && (res.status == pmpd_pkg::ST_BAD_LEN || res.status == pmpd_pkg::ST_TRUNC), !active_q)
	`PMPD_ASSERT_NOW(a_pos_bound, clk, arst_n, active_q, pos_q != 8'hFF)
	`PMPD_ASSERT_NOW(a_quad_fields, clk, arst_n, res_valid && !res.quad_flag, res.vertex_d == 16'd0)

endmodule

`default_nettype wire

>>> rtl/core/pmpd_out_stage.sv
// Result register that holds one result beat until the consumer takes it.
`default_nettype none

module pmpd_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire pmpd_pkg::result_t res,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   slot_free,
	output pmpd_pkg::result_t      res_q
);

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/model_primitive_packet_decoder_unit.sv
// Top level of the primitive packet decoder: input register, decoder and result register.
//
//   Channel   Signals                                   Role
//   input     in_valid/in_ready, block_start,           one 32-bit word of the block
//             data_word, data_end
//   output    out_valid/out_ready, status, red, green,  one primitive or block status
//             blue, vertex_a..vertex_d, quad_flag
//   config    cfg_wr_en, cfg_wr_data                    packets per block
//
// A word beat is registered, decoded from the input register and its result, if any, is
// loaded into the result register; one word is taken per cycle unless the output stalls.
// The decoder moves forward only when the result register is empty or being drained.
// Reset clears the parser to idle and sets the packet count to one.
// A stall on the output holds the word in the input register and then stops the input.
`default_nettype none

module model_primitive_packet_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        block_start,
	input  wire logic [31:0] data_word,
	input  wire logic        data_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [15:0]      vertex_a,
	output logic [15:0]      vertex_b,
	output logic [15:0]      vertex_c,
	output logic [15:0]      vertex_d,
	output logic             quad_flag
);

	pmpd_pkg::in_beat_t in_beat;
	pmpd_pkg::in_beat_t beat_s1;
	pmpd_pkg::result_t  res;
	pmpd_pkg::result_t  res_q;
	logic               valid_s1;
	logic               advance;
	logic               slot_free;
	logic               res_valid;

	assign in_beat.block_start = block_start;
	assign in_beat.data_word   = data_word;
	assign in_beat.data_end    = data_end;

	assign advance = valid_s1 && slot_free;

	pmpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	pmpd_decode u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.beat_s1     (beat_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	pmpd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.slot_free (slot_free),
		.res_q     (res_q)
	);

	assign status    = res_q.status;
	assign red       = res_q.red;
	assign green     = res_q.green;
	assign blue      = res_q.blue;
	assign vertex_a  = res_q.vertex_a;
	assign vertex_b  = res_q.vertex_b;
	assign vertex_c  = res_q.vertex_c;
	assign vertex_d  = res_q.vertex_d;
	assign quad_flag = res_q.quad_flag;

endmodule

`default_nettype wire
